// ===== src/sdms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdms_pkg: shared types and constants of the digest membership search
// Field widths, item kind codes, the packed 256-bit key type and the result
// struct of the compare unit.
// ----------------------------------------------------------------------------
package sdms_pkg;

    localparam int WORD_W        = 64;
    localparam int WORDS         = 4;
    localparam int KEY_W         = WORD_W * WORDS;
    localparam int SLOT_W        = 10;
    localparam int POS_W         = 11;
    localparam int DEPTH_DEFAULT = 1024;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // word 0 sits in the top bits, so a plain unsigned compare gives key order
    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

endpackage

// ===== src/sorted_digest_membership_search_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_digest_membership_search_unit: lower-bound search over a digest table
// Steps: a load word is written to the table when accepted. A query word runs
//   P probes (at most floor(log2(len)) + 1), each a table read in S_PROBE and
//   a compare in S_CMP, then reads the lower-bound entry and posts from S_FIN.
// Throughput: one query at a time; the input is stalled until the query ends.
// Reset: synchronous, active low; clears the sequencer, the length register
//   and the output valid. Table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_digest_membership_search_unit
    import sdms_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: entries_in_use
    input  logic                 i_cfg_we,
    input  logic [POS_W-1:0]     i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_kind,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [WORD_W-1:0]    i_key_word0,
    input  logic [WORD_W-1:0]    i_key_word1,
    input  logic [WORD_W-1:0]    i_key_word2,
    input  logic [WORD_W-1:0]    i_key_word3,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_found,
    output logic [POS_W-1:0]     o_position
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,  // take loads and queries
        S_PROBE = 4'b0010,  // issue the table read for the next probe
        S_CMP   = 4'b0100,  // compare the probed entry, narrow the range
        S_FIN   = 4'b1000   // entry at lower bound is read: deliver result
    } t_state;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_entries;
    logic [POS_W-1:0]   r_len, n_len;
    logic [POS_W-1:0]   r_lo, n_lo;
    logic [POS_W-1:0]   r_count, n_count;
    logic [POS_W-1:0]   r_mid, n_mid;
    t_key               r_key;
    logic               r_out_valid;
    logic               r_found;
    logic [POS_W-1:0]   r_position;

    logic               w_in_acc;
    logic               w_out_free;
    logic [POS_W-1:0]   w_step;
    logic [POS_W-1:0]   w_mid;
    logic [POS_W-1:0]   w_len_sat;
    t_key               w_key_in;
    logic               w_ram_we;
    logic               w_ram_re;
    logic [ADDR_W-1:0]  w_ram_raddr;
    t_key               w_entry;
    t_cmp_res           w_cmp;

    // ---- handshakes --------------------------------------------------------
    // Only the idle sequencer takes a word; a pending result does not block it.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    // The output register is free when empty or being emptied this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_key_in = {i_key_word0, i_key_word1, i_key_word2, i_key_word3};

    // Saturate the search length to the table depth.
    assign w_len_sat = (32'(r_entries) > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH) : r_entries;

    // Halving step: probe at lo + count/2.
    assign w_step = r_count >> 1;
    assign w_mid  = r_lo + w_step;

    // Drop loads aimed beyond the table.
    assign w_ram_we = w_in_acc && (i_kind == KIND_LOAD) && (32'(i_slot) < TABLE_DEPTH);

    // ---- configuration -----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (i_cfg_we) begin
            r_entries <= i_cfg_data;
        end
    end

    // ---- sequencer ---------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_lo        = r_lo;
        n_count     = r_count;
        n_mid       = r_mid;
        w_ram_re    = 1'b0;
        w_ram_raddr = ADDR_W'(w_mid);
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_kind == KIND_QUERY)) begin
                    n_len   = w_len_sat;
                    n_lo    = '0;
                    n_count = w_len_sat;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                w_ram_re = 1'b1;
                if (r_count == '0) begin
                    // range is empty: fetch the entry at the lower bound
                    w_ram_raddr = ADDR_W'(r_lo);
                    n_state     = S_FIN;
                end else begin
                    n_mid   = w_mid;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (w_cmp.lt) begin
                    // probed entry below key: advance past it
                    n_lo    = r_mid + POS_W'(1);
                    n_count = r_count - w_step - POS_W'(1);
                end else begin
                    n_count = w_step;
                end
                n_state = S_PROBE;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_lo    <= n_lo;
        r_count <= n_count;
        r_mid   <= n_mid;
        if (w_in_acc && (i_kind == KIND_QUERY)) begin
            r_key <= w_key_in;
        end
    end

    // ---- digest table and compare unit -------------------------------------
    sdms_ram #(
        .WIDTH  (KEY_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (ADDR_W'(i_slot)),
        .i_wdata (w_key_in),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_entry)
    );

    sdms_cmp u_cmp (
        .i_entry (w_entry),
        .i_key   (r_key),
        .o_res   (w_cmp)
    );

    // ---- output register ---------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && w_out_free) begin
            // a lower bound at the end of the range never matches
            r_found    <= (r_lo < r_len) && w_cmp.eq;
            r_position <= r_lo;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;

    // ---- assertions --------------------------------------------------------
    a_range_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PROBE) || (r_state == S_CMP)) |->
            (({1'b0, r_lo} + {1'b0, r_count}) <= {1'b0, r_len}))
        else $error("search range runs past the search length");

    a_cmp_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_count != '0))
        else $error("compare step entered with an empty range");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_kind == KIND_QUERY)) |=> (r_state == S_PROBE))
        else $error("accepted query did not start probing");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && w_out_free) |=>
            (o_out_valid && (o_position <= r_len)))
        else $error("finished query left no valid result in range");

endmodule

// ===== src/sdms_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdms_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module sdms_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last word while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sdms_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdms_cmp: shared 256-bit key compare unit
// Gives entry-less-than-key and entry-equal-to-key for one probe.
// ----------------------------------------------------------------------------
module sdms_cmp
    import sdms_pkg::*;
(
    input  t_key     i_entry,
    input  t_key     i_key,
    output t_cmp_res o_res
);

    always_comb begin
        o_res.lt = (i_entry < i_key);
        o_res.eq = (i_entry == i_key);
    end

endmodule

// ===== tb/sorted_digest_membership_search_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_digest_membership_search_unit_tb: self-checking bench of the search
// Loads digest tables of many sizes, mostly sorted and sometimes jumbled,
// sets the search length and sends lookups. A mirror of the table runs the
// same halving lower-bound search, and every result is checked against it.
// Both sides idle in random bursts.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                        found;
    logic [sdms_pkg::POS_W-1:0]  position;
} lookup_answer_t;

// Mirror of the digest table with the lower-bound search and the queue of
// answers that are still on their way out of the block.
class digest_search_board;
    sdms_pkg::t_key              digests [sdms_pkg::DEPTH_DEFAULT];
    logic [sdms_pkg::POS_W-1:0]  span;
    lookup_answer_t              outstanding [$];
    int                          mismatches;
    int                          loads;
    int                          lookups;
    int                          hits;

    function new();
        span       = '0;
        mismatches = 0;
        loads      = 0;
        lookups    = 0;
        hits       = 0;
    endfunction

    function void set_span(logic [sdms_pkg::POS_W-1:0] value);
        span = value;
    endfunction

    // Apply a load to the mirror, or search the mirror and queue the answer.
    function void note_word(logic kind, logic [sdms_pkg::SLOT_W-1:0] slot,
                            sdms_pkg::t_key key);
        int unsigned    reach;
        int unsigned    lo;
        int unsigned    count;
        int unsigned    stride;
        int unsigned    mid;
        lookup_answer_t want;
        if (kind == sdms_pkg::KIND_LOAD) begin
            digests[slot] = key;
            loads++;
            return;
        end
        // a length above the depth searches the whole table
        reach = (span > sdms_pkg::DEPTH_DEFAULT) ? sdms_pkg::DEPTH_DEFAULT : span;
        lo    = 0;
        count = reach;
        while (count > 0) begin
            stride = count / 2;
            mid    = lo + stride;
            if (digests[mid] < key) begin
                lo    = mid + 1;
                count = count - (stride + 1);
            end else begin
                count = stride;
            end
        end
        want.found    = (lo < reach) && (digests[lo] == key);
        want.position = sdms_pkg::POS_W'(lo);
        outstanding.push_back(want);
        lookups++;
        if (want.found)
            hits++;
    endfunction

    task report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    task check_result(logic found, logic [sdms_pkg::POS_W-1:0] position);
        lookup_answer_t want;
        if (outstanding.size() == 0) begin
            report_mismatch($sformatf("result found=%0b position=%0d with no lookup open",
                                      found, position));
            return;
        end
        want = outstanding.pop_front();
        if (found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
        if (position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      position, want.position));
    endtask
endclass

module sorted_digest_membership_search_unit_tb;
    import sdms_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int FULL_AT      = 40;    // words sent before the whole table is filled
    localparam int CALM_AT      = 1200;  // words sent before idling stops
    localparam int WORDS_TARGET = 1250;  // words sent before the stimulus stops
    localparam int SETTLE       = 4;     // cycles for a load to finish before a write
    localparam int TAIL         = 30;    // cycles to wait after the last answer

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [POS_W-1:0]   i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_kind;
    logic [SLOT_W-1:0]  i_slot;
    logic [WORD_W-1:0]  i_key_word0;
    logic [WORD_W-1:0]  i_key_word1;
    logic [WORD_W-1:0]  i_key_word2;
    logic [WORD_W-1:0]  i_key_word3;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_found;
    logic [POS_W-1:0]   o_position;

    digest_search_board ledger = new();

    int                 sent_words  = 0;    // words accepted by the block
    int                 settings    = 0;    // length register writes
    int                 widest_span = 0;
    int                 gap_pct     = 0;    // chance of a sender gap before a word
    int                 stall_pct   = 0;    // chance of a receiver stall burst
    int                 stall_left  = 0;
    int unsigned        ready_prefix = 0;   // leading slots that hold a loaded digest
    logic [POS_W-1:0]   cur_span    = '0;
    bit                 calm        = 1'b0; // set for the idle-free end of the run
    bit                 full_done   = 1'b0;

    sorted_digest_membership_search_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_slot      (i_slot),
        .i_key_word0 (i_key_word0),
        .i_key_word1 (i_key_word1),
        .i_key_word2 (i_key_word2),
        .i_key_word3 (i_key_word3),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_found     (o_found),
        .o_position  (o_position)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: stall in random bursts, never once the run is calm.
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(99) < stall_pct) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(16, 0);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Check every result word that the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            ledger.check_result(o_found, o_position);
    end

    // Pick an idling share: none, light or heavy.
    function automatic int idle_share();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 8;
            default: return 30;
        endcase
    endfunction

    function automatic t_key rand_key();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Advance a sorted run: a duplicate, a nudge in the low word, or a jump
    // at a higher word so that neighbours differ at every word position.
    function automatic t_key next_sorted(t_key prev);
        case ($urandom_range(9))
            0:       return prev;
            1, 2, 3: return prev + t_key'($urandom_range(3, 1));
            4, 5:    return prev + (t_key'({$urandom, $urandom}) << 64);
            6, 7:    return prev + (t_key'({$urandom, $urandom}) << 128);
            default: return prev + (t_key'($urandom) << 192);
        endcase
    endfunction

    // Choose a lookup key: mostly copies and near misses of table entries
    // inside the searched span, plus the extremes and pure noise.
    function automatic t_key probe_key(int unsigned reach);
        t_key        k;
        int unsigned idx;
        int          mode;
        mode = $urandom_range(11);
        if (reach == 0 && mode < 8)
            mode = 10;
        idx = (reach == 0) ? 0 : $urandom_range(reach - 1);
        case (mode)
            0, 1, 2, 3: k = ledger.digests[idx];
            4, 5:       k = ledger.digests[idx] + t_key'(1);
            6:          k = ledger.digests[idx] - t_key'(1);
            7: begin
                k = ledger.digests[idx];
                k[$urandom_range(KEY_W - 1)] ^= 1'b1;
            end
            8:          k = '0;
            9:          k = '1;
            default:    k = rand_key();
        endcase
        return k;
    endfunction

    // Drive one word, optionally after a sender gap, and hold it until taken.
    task automatic send_word(logic kind, logic [SLOT_W-1:0] slot, t_key key);
        if (!calm && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_slot      <= slot;
        i_key_word0 <= key[KEY_W-1 -: WORD_W];
        i_key_word1 <= key[KEY_W-1-WORD_W -: WORD_W];
        i_key_word2 <= key[KEY_W-1-2*WORD_W -: WORD_W];
        i_key_word3 <= key[WORD_W-1:0];
        do @(posedge i_clk); while (o_in_stall);
        ledger.note_word(kind, slot, key);
        sent_words++;
    endtask

    task automatic load_entry(logic [SLOT_W-1:0] slot, t_key key);
        send_word(KIND_LOAD, slot, key);
    endtask

    task automatic query_key(t_key key);
        send_word(KIND_QUERY, SLOT_W'($urandom_range(DEPTH - 1)), key);
    endtask

    // Drain the block, let a trailing load finish, then write the length.
    task automatic set_span(logic [POS_W-1:0] value);
        i_in_valid <= 1'b0;
        while (ledger.outstanding.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        ledger.set_span(value);
        cur_span = value;
        settings++;
        if (value > widest_span)
            widest_span = value;
    endtask

    task automatic query_burst(int n);
        int unsigned reach;
        reach = (cur_span > DEPTH) ? DEPTH : cur_span;
        repeat (n) query_key(probe_key(reach));
    endtask

    // Fill every slot in order with one long sorted run, then search the
    // whole table, including lengths beyond the depth.
    task automatic full_phase();
        t_key run;
        gap_pct   = 5;
        stall_pct = idle_share();
        run = rand_key() >> 2;
        for (int i = 0; i < DEPTH; i++) begin
            load_entry(SLOT_W'(i), run);
            run = next_sorted(run);
        end
        ready_prefix = DEPTH;
        full_done    = 1'b1;
        set_span(POS_W'(DEPTH));
        query_burst(40);
        set_span('1);
        query_burst(8);
        set_span(POS_W'($urandom_range(2046, DEPTH + 1)));
        query_burst(6);
    endtask

    // Reload a short prefix, pick a length the loaded slots can carry, and
    // search it with a few loads mixed among the lookups.
    task automatic small_phase();
        int               n;
        int               pick;
        t_key             run;
        bit               jumbled;
        logic [POS_W-1:0] span_pick;
        gap_pct   = idle_share();
        stall_pct = idle_share();
        n       = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(24, 1);
        jumbled = ($urandom_range(7) == 0);
        run     = ($urandom_range(3) == 0) ? '0 : (rand_key() >> 1);
        for (int i = 0; i < n; i++) begin
            load_entry(SLOT_W'(i), jumbled ? rand_key() : run);
            run = next_sorted(run);
        end
        if (n > ready_prefix)
            ready_prefix = n;
        pick = $urandom_range(9);
        if (pick == 0)
            span_pick = '0;
        else if (pick == 1)
            span_pick = POS_W'($urandom_range(ready_prefix));
        else if (pick == 2 && full_done)
            span_pick = POS_W'($urandom_range(2047, DEPTH));
        else
            span_pick = POS_W'(n);
        set_span(span_pick);
        repeat ($urandom_range(16, 4)) begin
            // an odd load in the middle may leave the table unsorted
            if ($urandom_range(7) == 0)
                load_entry(SLOT_W'($urandom_range(DEPTH - 1)), rand_key());
            query_burst(1);
        end
    endtask

    // Give up if the run hangs.
    initial begin
        #6_000_000;
        $display("run stopped by the watchdog at %0t", $time);
        $display("sorted_digest_membership_search_unit_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        t_key k1;
        t_key k2;

        // initialise every input before the first edge
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_kind      <= KIND_LOAD;
        i_slot      <= '0;
        i_key_word0 <= '0;
        i_key_word1 <= '0;
        i_key_word2 <= '0;
        i_key_word3 <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Search an empty span at the reset length first.
        gap_pct   = 20;
        stall_pct = 20;
        query_key('0);
        query_key('1);

        // Small table: zero, two mid keys that differ only in the top word, all ones.
        k1 = rand_key() >> 3;
        k2 = k1 + (t_key'(1) << 200);
        load_entry(SLOT_W'(0), '0);
        load_entry(SLOT_W'(1), k1);
        load_entry(SLOT_W'(2), k2);
        load_entry(SLOT_W'(3), '1);
        load_entry(SLOT_W'(DEPTH - 1), rand_key());   // top slot, outside the span
        ready_prefix = 4;
        set_span(POS_W'(4));
        query_key('0);                  // hit at the bottom
        query_key('1);                  // hit at the top
        query_key(k1);                  // exact hit inside
        query_key(k2 - t_key'(1));      // miss just below an entry
        query_key(k2 + t_key'(2));      // miss just above an entry

        // Key above every entry in the span: position equals the length.
        set_span(POS_W'(1));
        query_key('1);
        set_span(POS_W'(3));
        query_key('1);

        // Break the order and search the same probe path.
        load_entry(SLOT_W'(1), '1);
        query_key(k2);

        // Random part: short phases, one fill of the whole table, then at
        // least one calm phase to close the run.
        while (!(calm && sent_words >= WORDS_TARGET)) begin
            if (full_done && sent_words >= CALM_AT)
                calm = 1'b1;
            if (!full_done && sent_words >= FULL_AT)
                full_phase();
            else
                small_phase();
        end

        // Drain and let the tail settle.
        i_in_valid <= 1'b0;
        while (ledger.outstanding.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (ledger.outstanding.size() != 0)
            ledger.report_mismatch($sformatf("%0d lookups never answered",
                                             ledger.outstanding.size()));

        $display("covered %0d words: %0d loads and %0d lookups, %0d of them hits",
                 sent_words, ledger.loads, ledger.lookups, ledger.hits);
        $display("%0d length settings up to %0d, whole table filled, %0d mismatches",
                 settings, widest_span, ledger.mismatches);
        if (ledger.mismatches == 0) begin
            $display("sorted_digest_membership_search_unit_tb OK");
        end else begin
            $display("sorted_digest_membership_search_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
